// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the postfix evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset
`define PEE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pee assertion failed");

// Condition must never be seen outside reset
`define PEE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pee forbidden condition seen");

`else

`define PEE_ASSERT(lbl, clk, rst_n, prop)
`define PEE_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg
// Types, constants and codes of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

    // Sizing
    localparam int STACK_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int OUT_TDATA_W = ((VALUE_WIDTH + STATUS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_WIDTH - STATUS_W;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [3:0]        DEC_BASE = 4'd10;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_OP,
        S_CALC,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

    // One decoded token: optional operand push, optional operator, end flag
    typedef struct packed {
        logic                   has_num;
        logic [VALUE_WIDTH-1:0] num;
        t_op                    op;
        logic                   last;
    } t_token;

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [VALUE_WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix integer expression streamed in one character at a time.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one ASCII character per request in tdata, with tlast set on
//   the final character of the expression. Digit runs form operands; + - * /
//   pop two operands and push the result; anything else separates tokens.
//   m_axis carries one request per expression: the top of the stack and a
//   status (ok, underflow, overflow, divide by zero, empty stack at end).
// Flow:
//   A character is accepted whenever the queue has room. Tokens go through
//   a two-entry queue to the stack sequencer, which pops a token while idle,
//   pushes any operand, and for an operator checks the operands, computes
//   the result (/ waits on the serial divider) and writes it back. On the
//   last token it then loads the output register, which raises tvalid.
//   s_axis_tready drops only when the queue is full.
// Reset and stall:
//   Synchronous active-low reset empties the stack, queue and output; no
//   clearing pass is needed. A stalled m_axis holds its request in the output
//   register while the next expression's characters keep flowing in.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pee_pkg::CHAR_W-1:0]          s_axis_tdata,  // [7:0] char_byte
    input  logic                                s_axis_tlast,  // last_char
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pee_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // [31:0] value, [34:32] status
);
    import pee_pkg::*;

    logic                   w_full;
    logic                   w_wr_en;
    t_token                 w_wr_tok;
    logic                   w_q_valid;
    t_token                 w_q_tok;
    logic                   w_q_pop;
    logic [VALUE_WIDTH-1:0] w_value;
    t_status                w_status;

    // Character classifier
    pee_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_full   (w_full),
        .o_wr_en  (w_wr_en),
        .o_wr_tok (w_wr_tok)
    );

    // Token queue
    pee_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_wr_en),
        .i_wr_tok (w_wr_tok),
        .o_full   (w_full),
        .o_valid  (w_q_valid),
        .o_tok    (w_q_tok),
        .i_pop    (w_q_pop)
    );

    // Stack sequencer
    pee_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_tok   (w_q_tok),
        .o_q_pop   (w_q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (w_value),
        .o_status  (w_status)
    );

    // Result packing
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_status, w_value};

endmodule

// ===== rtl/pee_ram.sv =====
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pee_front.sv =====
// ----------------------------------------------------------------------------
// pee_front
// Character classifier: builds decimal operands and emits tokens.
// ----------------------------------------------------------------------------
module pee_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [pee_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_last,
    output logic                        o_ready,
    input  logic                        i_full,
    output logic                        o_wr_en,
    output pee_pkg::t_token             o_wr_tok
);
    import pee_pkg::*;

    logic [VALUE_WIDTH-1:0] r_acc;
    logic [VALUE_WIDTH-1:0] n_acc;
    logic                   r_in_num;
    logic                   n_in_num;
    logic                   w_accept;
    logic                   w_is_digit;
    logic [3:0]             w_digit;
    logic [VALUE_WIDTH-1:0] w_acc_next;
    t_op                    w_op;
    t_token                 w_tok;
    logic                   w_emit;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    // Classify the character
    always_comb begin
        w_is_digit = i_char inside {[CH_ZERO:CH_NINE]};
        case (i_char)
            CH_PLUS:  w_op = OP_ADD;
            CH_MINUS: w_op = OP_SUB;
            CH_STAR:  w_op = OP_MUL;
            CH_SLASH: w_op = OP_DIV;
            default:  w_op = OP_NONE;
        endcase
    end

    // acc * 10 + digit as two shifts and two adds, wrapping at the value width
    assign w_digit    = 4'(i_char - CH_ZERO);
    assign w_acc_next = {r_acc[VALUE_WIDTH-4:0], 3'b000}
                      + {r_acc[VALUE_WIDTH-2:0], 1'b0}
                      + VALUE_WIDTH'(w_digit);

    // Token assembly and accumulator update
    always_comb begin
        n_acc    = r_acc;
        n_in_num = r_in_num;
        w_tok    = '0;
        w_emit   = 1'b0;
        if (w_is_digit) begin
            w_tok.has_num = 1'b1;
            w_tok.num     = w_acc_next;
            w_tok.op      = OP_NONE;
            w_tok.last    = i_last;
            w_emit        = i_last;
            n_acc         = i_last ? '0 : w_acc_next;
            n_in_num      = !i_last;
        end else begin
            w_tok.has_num = r_in_num;
            w_tok.num     = r_acc;
            w_tok.op      = w_op;
            w_tok.last    = i_last;
            w_emit        = r_in_num || (w_op != OP_NONE) || i_last;
            n_acc         = '0;
            n_in_num      = 1'b0;
        end
    end

    assign o_wr_en  = w_accept && w_emit;
    assign o_wr_tok = w_tok;

    // Operand accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_in_num <= 1'b0;
        end else if (w_accept) begin
            r_acc    <= n_acc;
            r_in_num <= n_in_num;
        end
    end

endmodule

// ===== rtl/pee_queue.sv =====
// ----------------------------------------------------------------------------
// pee_queue
// Short token queue between the classifier and the stack sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pee_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  pee_pkg::t_token i_wr_tok,
    output logic            o_full,
    output logic            o_valid,
    output pee_pkg::t_token o_tok,
    input  logic            i_pop
);
    import pee_pkg::*;

    t_token            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_do_pop;

    assign o_full   = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_tok    = r_mem[r_rptr];
    assign w_do_pop = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wptr] <= i_wr_tok;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_wr_en, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `PEE_ASSERT_NEVER(a_q_write_full, i_clk, i_rst_n, i_wr_en && o_full)
    `PEE_ASSERT(a_q_cnt_bound, i_clk, i_rst_n, r_cnt <= QCNT_W'(QUEUE_DEPTH))
    `PEE_ASSERT(a_q_pop_step, i_clk, i_rst_n, (w_do_pop && !i_wr_en) |=> (r_cnt == $past(r_cnt) - 1'b1))

endmodule

// ===== rtl/pee_div.sv =====
// ----------------------------------------------------------------------------
// pee_div
// Signed divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pee_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pee_pkg::t_div_req i_req,
    output pee_pkg::t_div_rsp o_rsp
);
    import pee_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] r_den;
    logic                   w_na;
    logic                   w_nb;
    logic [VALUE_WIDTH-1:0] w_ma;
    logic [VALUE_WIDTH-1:0] w_mb;
    logic [VALUE_WIDTH:0]   w_rem_sh;
    logic [VALUE_WIDTH:0]   w_trial;

    // Operand magnitudes
    assign w_na = i_req.dividend[VALUE_WIDTH-1];
    assign w_nb = i_req.divisor[VALUE_WIDTH-1];
    assign w_ma = w_na ? ('0 - i_req.dividend) : i_req.dividend;
    assign w_mb = w_nb ? ('0 - i_req.divisor) : i_req.divisor;

    // Restoring step
    assign w_rem_sh = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_trial  = w_rem_sh - {1'b0, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(VALUE_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= w_ma;
            r_den <= w_mb;
            r_neg <= w_na ^ w_nb;
        end else if (r_busy) begin
            if (!w_trial[VALUE_WIDTH]) begin
                r_rem <= w_trial[VALUE_WIDTH-1:0];
            end else begin
                r_rem <= w_rem_sh[VALUE_WIDTH-1:0];
            end
            r_quo <= {r_quo[VALUE_WIDTH-2:0], !w_trial[VALUE_WIDTH]};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? ('0 - r_quo) : r_quo;

endmodule

// ===== rtl/pee_back.sv =====
// ----------------------------------------------------------------------------
// pee_back
// Stack sequencer: pushes operands, applies operators, forms the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pee_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  pee_pkg::t_token                   i_q_tok,
    output logic                              o_q_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [pee_pkg::VALUE_WIDTH-1:0]   o_value,
    output pee_pkg::t_status                  o_status
);
    import pee_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    t_token                 r_tok;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    t_status                r_err;
    t_status                n_err;
    logic [VALUE_WIDTH-1:0] r_top;
    logic [VALUE_WIDTH-1:0] n_top;
    logic [VALUE_WIDTH-1:0] r_res;
    logic [VALUE_WIDTH-1:0] n_res;
    logic                   r_ovalid;
    logic                   n_ovalid;
    logic [VALUE_WIDTH-1:0] r_oval;
    logic [VALUE_WIDTH-1:0] n_oval;
    t_status                r_ostat;
    t_status                n_ostat;

    logic                   w_we;
    logic [ADDR_W-1:0]      w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [ADDR_W-1:0]      w_raddr;
    logic [VALUE_WIDTH-1:0] w_lhs;
    logic [CNT_W-1:0]       w_cnt_m2;
    t_state                 w_finish;
    t_div_req               w_div_req;
    t_div_rsp               w_div_rsp;

    assign w_cnt_m2 = r_count - CNT_W'(2);
    assign w_raddr  = w_cnt_m2[ADDR_W-1:0];
    assign w_finish = r_tok.last ? S_OUT : S_IDLE;

    // Operand stack storage
    pee_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_lhs)
    );

    // Divider
    pee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_tok <= i_q_tok;
        end
        r_top   <= n_top;
        r_res   <= n_res;
        r_oval  <= n_oval;
        r_ostat <= n_ostat;
    end

    // Next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_err     = r_err;
        n_top     = r_top;
        n_res     = r_res;
        n_ovalid  = r_ovalid && !i_ready;
        n_oval    = r_oval;
        n_ostat   = r_ostat;
        o_q_pop   = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_count[ADDR_W-1:0];
        w_wdata   = r_tok.num;
        w_div_req = '0;
        w_div_req.dividend = w_lhs;
        w_div_req.divisor  = r_top;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = S_PUSH;
                end
            end

            // Push a pending operand
            S_PUSH: begin
                if (r_tok.has_num && (r_err == ST_OK)) begin
                    if (r_count == CNT_W'(STACK_DEPTH)) begin
                        n_err = ST_OVERFLOW;
                    end else begin
                        w_we    = 1'b1;
                        n_top   = r_tok.num;
                        n_count = r_count + 1'b1;
                    end
                end
                n_state = (r_tok.op != OP_NONE) ? S_OP : w_finish;
            end

            // Check operands and fetch the left one
            S_OP: begin
                if (r_err != ST_OK) begin
                    n_state = w_finish;
                end else if (r_count < CNT_W'(2)) begin
                    n_err   = ST_UNDERFLOW;
                    n_state = w_finish;
                end else begin
                    n_state = S_CALC;
                end
            end

            // Left operand from memory, right operand cached on top
            S_CALC: begin
                case (r_tok.op)
                    OP_ADD: begin
                        n_res   = w_lhs + r_top;
                        n_state = S_WB;
                    end
                    OP_SUB: begin
                        n_res   = w_lhs - r_top;
                        n_state = S_WB;
                    end
                    OP_MUL: begin
                        n_res   = w_lhs * r_top;
                        n_state = S_WB;
                    end
                    OP_DIV: begin
                        if (r_top == '0) begin
                            n_err   = ST_DIVZERO;
                            n_state = w_finish;
                        end else begin
                            w_div_req.start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    default: begin
                        n_state = w_finish;
                    end
                endcase
            end

            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_res   = w_div_rsp.quotient;
                    n_state = S_WB;
                end
            end

            // Two popped, one pushed: result lands in the lower slot
            S_WB: begin
                w_we    = 1'b1;
                w_waddr = w_raddr;
                w_wdata = r_res;
                n_top   = r_res;
                n_count = r_count - 1'b1;
                n_state = w_finish;
            end

            // Load the output register once it is free, then clear
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    if (r_err != ST_OK) begin
                        n_oval  = '0;
                        n_ostat = r_err;
                    end else if (r_count == '0) begin
                        n_oval  = '0;
                        n_ostat = ST_EMPTY;
                    end else begin
                        n_oval  = r_top;
                        n_ostat = ST_OK;
                    end
                    n_count = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid  = r_ovalid;
    assign o_value  = r_oval;
    assign o_status = r_ostat;

    `PEE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(STACK_DEPTH))
    `PEE_ASSERT(a_wb_two, i_clk, i_rst_n, (r_state == S_WB) |-> (r_count >= CNT_W'(2)))
    `PEE_ASSERT(a_err_value_zero, i_clk, i_rst_n, (r_ovalid && (r_ostat != ST_OK)) |-> (r_oval == '0))
    `PEE_ASSERT_NEVER(a_div_by_zero, i_clk, i_rst_n, w_div_req.start && (w_div_req.divisor == '0))

endmodule
